@@ rtl/nps_pkg.sv @@
package nps_pkg;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PUSH
  } state_e;

  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned WAIT_W  = 20;
  localparam int unsigned TOTAL_W = 24;
  localparam int unsigned COUNT_W = 5;

  localparam logic [WAIT_W-1:0]  WAIT_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

@@ rtl/nonpreemptive_priority_scheduler.sv @@
// channel  direction  transfer when             payload
// in       input      in_valid_i & in_ready_o   burst_time_i, priority_req_i, last_i
// out      output     out_valid_o & out_ready_i job_id_o .. final_res_o (10 fields)
//
// loading takes one job per cycle; a job arriving with last_i set closes the batch
// each result costs one scan of the job memory (one read port) plus one push, so
// a batch of n jobs takes n scans and n pushes to emit
// reset clears the job count, the overflow flag and the control state; the job
// memory needs no clearing since only entries of the open batch are read
// the output register holds a result while out_ready_i is low; the scan for the
// next result runs on and then waits in the push state
module nonpreemptive_priority_scheduler
  import nps_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BURST_W-1:0]   burst_time_i,
  input  logic [PRIO_W-1:0]    priority_req_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ID_W-1:0]      job_id_o,
  output logic [BURST_W-1:0]   job_burst_o,
  output logic [PRIO_W-1:0]    job_priority_o,
  output logic [WAIT_W-1:0]    wait_time_o,
  output logic [WAIT_W-1:0]    turnaround_time_o,
  output logic [TOTAL_W-1:0]   total_wait_o,
  output logic [TOTAL_W-1:0]   total_turnaround_o,
  output logic [COUNT_W-1:0]   job_count_o,
  output logic                 dropped_o,
  output logic                 final_res_o
);

  // index into the job memory and a count that can hold MAX_JOBS itself
  localparam int unsigned IdxW  = $clog2(MAX_JOBS);
  localparam int unsigned CntW  = $clog2(MAX_JOBS + 1);
  localparam int unsigned KeyW  = PRIO_W + IdxW;
  localparam int unsigned WordW = BURST_W + PRIO_W;
  // exact sums: a wait is below n * 2^16, a total below n * n * 2^16
  localparam int unsigned WaitW = ((BURST_W + CntW) > WAIT_W) ? (BURST_W + CntW)
                                                              : (WAIT_W + 1);
  localparam int unsigned TotW  = ((BURST_W + 2 * CntW) > TOTAL_W) ? (BURST_W + 2 * CntW)
                                                                   : (TOTAL_W + 1);

  state_e state_q, state_d;

  logic [CntW-1:0]  count_q;
  logic             ovf_q;
  logic [CntW-1:0]  issue_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic             best_found_q;
  logic             first_q;
  logic [CntW-1:0]  emit_q;
  logic             out_valid_q;

  logic [KeyW-1:0]    best_key_q;
  logic [BURST_W-1:0] best_burst_q;
  logic [KeyW-1:0]    prev_key_q;
  logic [WaitW-1:0]   wait_q;
  logic [TotW-1:0]    sum_wait_q;
  logic [TotW-1:0]    sum_tat_q;

  logic             in_fire;
  logic             out_fire;
  logic             push_en;
  logic             ram_re;
  logic             ram_we;
  logic [WordW-1:0] ram_rdata;

  logic [BURST_W-1:0] rd_burst;
  logic [PRIO_W-1:0]  rd_prio;
  logic [KeyW-1:0]    rd_key;
  logic               cand;
  logic               take;
  logic               scan_done;
  logic               is_final;

  logic [WaitW-1:0] tat;
  logic [TotW-1:0]  sum_wait_new;
  logic [TotW-1:0]  sum_tat_new;

  // jobs live in one memory word each: burst above priority, address is the id
  nps_ram #(
    .WIDTH (WordW),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({burst_time_i, priority_req_i}),
    .re_i    (ram_re),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign ram_we   = in_fire && (count_q < CntW'(MAX_JOBS));

  // selection scan: the next job is the smallest {priority, id} above the last one
  // emitted, which gives a stable order by priority
  assign rd_burst  = ram_rdata[WordW-1:PRIO_W];
  assign rd_prio   = ram_rdata[PRIO_W-1:0];
  assign rd_key    = {rd_prio, rd_idx_q};
  assign cand      = first_q || (rd_key > prev_key_q);
  assign take      = cand && (!best_found_q || (rd_key < best_key_q));
  assign scan_done = rd_vld_q && (CntW'(rd_idx_q) == (count_q - 1'b1));
  assign is_final  = ((emit_q + 1'b1) == count_q);

  assign tat          = wait_q + WaitW'(best_burst_q);
  assign sum_wait_new = sum_wait_q + TotW'(wait_q);
  assign sum_tat_new  = sum_tat_q + TotW'(tat);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && last_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_en) begin
          state_d = is_final ? ST_LOAD : ST_SCAN;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    push_en    = 1'b0;
    unique case (state_q)
      ST_LOAD: in_ready_o = 1'b1;
      ST_SCAN: ram_re = (issue_q < count_q);
      ST_PUSH: push_en = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      issue_q      <= '0;
      rd_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      first_q      <= 1'b0;
      emit_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ram_re;
      if (ram_re) begin
        issue_q <= issue_q + 1'b1;
      end
      if (rd_vld_q && take) begin
        best_found_q <= 1'b1;
      end
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        if (ram_we) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
        if (last_i) begin
          // batch closed: start the first scan
          issue_q      <= '0;
          best_found_q <= 1'b0;
          first_q      <= 1'b1;
          emit_q       <= '0;
        end
      end
      if (push_en) begin
        out_valid_q  <= 1'b1;
        first_q      <= 1'b0;
        emit_q       <= emit_q + 1'b1;
        issue_q      <= '0;
        best_found_q <= 1'b0;
        if (is_final) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= issue_q[IdxW-1:0];
    if (rd_vld_q && take) begin
      best_key_q   <= rd_key;
      best_burst_q <= rd_burst;
    end
    if (in_fire && last_i) begin
      wait_q     <= '0;
      sum_wait_q <= '0;
      sum_tat_q  <= '0;
    end
    if (push_en) begin
      prev_key_q         <= best_key_q;
      wait_q             <= tat;
      sum_wait_q         <= sum_wait_new;
      sum_tat_q          <= sum_tat_new;
      job_id_o           <= ID_W'(best_key_q[IdxW-1:0]);
      job_burst_o        <= best_burst_q;
      job_priority_o     <= best_key_q[KeyW-1:IdxW];
      wait_time_o        <= (wait_q > WaitW'(WAIT_MAX)) ? WAIT_MAX : wait_q[WAIT_W-1:0];
      turnaround_time_o  <= (tat > WaitW'(WAIT_MAX)) ? WAIT_MAX : tat[WAIT_W-1:0];
      total_wait_o       <= (sum_wait_new > TotW'(TOTAL_MAX)) ? TOTAL_MAX
                                                              : sum_wait_new[TOTAL_W-1:0];
      total_turnaround_o <= (sum_tat_new > TotW'(TOTAL_MAX)) ? TOTAL_MAX
                                                             : sum_tat_new[TOTAL_W-1:0];
      job_count_o        <= COUNT_W'(count_q);
      dropped_o          <= ovf_q;
      final_res_o        <= is_final;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/nps_ram.sv @@
module nps_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ test/nonpreemptive_priority_scheduler_tb.sv @@
`timescale 1ns / 100ps

module nonpreemptive_priority_scheduler_tb
  import nps_pkg::*;
();

  localparam int JOB_SLOTS   = 16;      // capacity of one batch in the block
  localparam int CYCLE_LIMIT = 400000;  // generous ceiling over the slowest legal run
  localparam int HOLD_CYCLES = 600;     // long receiver hold-off, fills the block
  localparam int RANDOM_JOBS = 404;     // random jobs after the directed table
  localparam int DRAIN_TAIL  = 60;      // quiet cycles after the last result

  // receiver stall modes
  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN,
    RDY_SPARSE
  } ready_mode_e;

  // one scheduled job as the block reports it
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [WAIT_W-1:0]  wait_time;
    logic [WAIT_W-1:0]  turnaround;
    logic [TOTAL_W-1:0] sum_wait;
    logic [TOTAL_W-1:0] sum_turn;
    logic [COUNT_W-1:0] count;
    logic               dropped;
    logic               last_one;
  } sched_res_t;

  // one row of the directed table; reps repeats the same job
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last;
    logic [5:0]         reps;
    logic               typed;
    sched_res_t         want;
  } job_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [BURST_W-1:0] burst_time_i;
  logic [PRIO_W-1:0]  priority_req_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ID_W-1:0]    job_id_o;
  logic [BURST_W-1:0] job_burst_o;
  logic [PRIO_W-1:0]  job_priority_o;
  logic [WAIT_W-1:0]  wait_time_o;
  logic [WAIT_W-1:0]  turnaround_time_o;
  logic [TOTAL_W-1:0] total_wait_o;
  logic [TOTAL_W-1:0] total_turnaround_o;
  logic [COUNT_W-1:0] job_count_o;
  logic               dropped_o;
  logic               final_res_o;

  // predictor state: the open batch in arrival order
  logic [BURST_W-1:0] held_burst[$];
  logic [PRIO_W-1:0]  held_prio[$];
  logic               held_overflow = 1'b0;
  sched_res_t         batch_res[JOB_SLOTS];

  sched_res_t schedule_q[$];  // predicted schedule entries, oldest first
  job_row_t   job_table[$];

  int   errors      = 0;
  int   cycle_count = 0;
  int   burst_left  = 0;
  logic sender_gaps = 1'b1;
  logic hold_req    = 1'b0;

  always #5 clk_i = ~clk_i;

  nonpreemptive_priority_scheduler #(
    .MAX_JOBS(JOB_SLOTS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .burst_time_i      (burst_time_i),
    .priority_req_i    (priority_req_i),
    .last_i            (last_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .job_id_o          (job_id_o),
    .job_burst_o       (job_burst_o),
    .job_priority_o    (job_priority_o),
    .wait_time_o       (wait_time_o),
    .turnaround_time_o (turnaround_time_o),
    .total_wait_o      (total_wait_o),
    .total_turnaround_o(total_turnaround_o),
    .job_count_o       (job_count_o),
    .dropped_o         (dropped_o),
    .final_res_o       (final_res_o)
  );

  // takes one accepted job; when it closes the batch, fills batch_res in
  // execution order and returns how many results the batch gives
  function automatic int schedule_job(input logic [BURST_W-1:0] b,
                                      input logic [PRIO_W-1:0] p, input logic l);
    int order[JOB_SLOTS];
    int n, key, j;
    longint unsigned start, done, sum_w, sum_t;
    // a full batch discards the job but flags the overflow
    if (held_burst.size() < JOB_SLOTS) begin
      held_burst.push_back(b);
      held_prio.push_back(p);
    end else begin
      held_overflow = 1'b1;
    end
    if (!l) return 0;
    n = held_burst.size();
    for (int i = 0; i < n; i++) order[i] = i;
    // stable insertion sort, equal priorities keep arrival order
    for (int i = 1; i < n; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && held_prio[order[j-1]] > held_prio[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    start = 0;
    sum_w = 0;
    sum_t = 0;
    for (int k = 0; k < n; k++) begin
      done = start + held_burst[order[k]];
      sum_w += start;
      sum_t += done;
      batch_res[k].id         = order[k][ID_W-1:0];
      batch_res[k].burst      = held_burst[order[k]];
      batch_res[k].prio       = held_prio[order[k]];
      batch_res[k].wait_time  = (start > WAIT_MAX) ? WAIT_MAX : start[WAIT_W-1:0];
      batch_res[k].turnaround = (done > WAIT_MAX) ? WAIT_MAX : done[WAIT_W-1:0];
      batch_res[k].sum_wait   = (sum_w > TOTAL_MAX) ? TOTAL_MAX : sum_w[TOTAL_W-1:0];
      batch_res[k].sum_turn   = (sum_t > TOTAL_MAX) ? TOTAL_MAX : sum_t[TOTAL_W-1:0];
      batch_res[k].count      = n[COUNT_W-1:0];
      batch_res[k].dropped    = held_overflow;
      batch_res[k].last_one   = (k == n - 1);
      start = done;
    end
    // batch emitted, a new one opens
    held_burst.delete();
    held_prio.delete();
    held_overflow = 1'b0;
    return n;
  endfunction

  function automatic job_row_t job_row(input logic [BURST_W-1:0] b,
                                       input logic [PRIO_W-1:0] p, input logic l,
                                       input int reps, input logic typed,
                                       input sched_res_t want);
    job_row_t r;
    r.burst = b;
    r.prio  = p;
    r.last  = l;
    r.reps  = reps[5:0];
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // offers one job until the transfer, books what it predicts, then maybe idles
  task automatic send_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
                          input logic l, input logic typed, input sched_res_t want);
    int n;
    int gap;
    in_valid_i     <= 1'b1;
    burst_time_i   <= b;
    priority_req_i <= p;
    last_i         <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n = schedule_job(b, p, l);
    // typed rows carry their own expectation, read off directly
    if (typed) begin
      schedule_q.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) schedule_q.push_back(batch_res[k]);
    end
    // sender bursts: a random run of back-to-back transfers, then a gap
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result side: every transfer is matched against the oldest prediction
  always @(posedge clk_i) begin : result_check
    sched_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (schedule_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t unexpected result: expected none actual job_id %0d",
                   $time, job_id_o);
      end else begin
        want = schedule_q.pop_front();
        check_field("job_id", 32'(want.id), 32'(job_id_o));
        check_field("job_burst", 32'(want.burst), 32'(job_burst_o));
        check_field("job_priority", 32'(want.prio), 32'(job_priority_o));
        check_field("wait_time", 32'(want.wait_time), 32'(wait_time_o));
        check_field("turnaround_time", 32'(want.turnaround), 32'(turnaround_time_o));
        check_field("total_wait", 32'(want.sum_wait), 32'(total_wait_o));
        check_field("total_turnaround", 32'(want.sum_turn), 32'(total_turnaround_o));
        check_field("job_count", 32'(want.count), 32'(job_count_o));
        check_field("dropped", 32'(want.dropped), 32'(dropped_o));
        check_field("final_res", 32'(want.last_one), 32'(final_res_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: stall modes that change after a random span, plus one long
  // hold-off on request so the block fills up and blocks its input
  initial begin : receiver
    ready_mode_e mode;
    int          span;
    logic [7:0]  pat;
    logic        hold_done;
    out_ready_i <= 1'b0;
    mode = RDY_ALWAYS;
    span = 0;
    pat = 8'b1101_0010;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (span == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 80);
      end
      span--;
      case (mode)
        RDY_ALWAYS: begin
          out_ready_i <= 1'b1;
        end
        RDY_RANDOM: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        RDY_PATTERN: begin
          out_ready_i <= pat[0];
          pat = {pat[0], pat[7:1]};
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // sender side: directed table, then random batches
  initial begin : stimulus
    int                 size;
    int                 sent;
    int                 batch;
    int                 pick;
    int                 prio_style;
    int                 burst_style;
    logic [PRIO_W-1:0]  prio_fix;
    logic [BURST_W-1:0] b;
    logic [PRIO_W-1:0]  p;

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    burst_time_i   <= '0;
    priority_req_i <= '0;
    last_i         <= 1'b0;

    // lone job, every field at its low end
    job_table.push_back(job_row(16'd0, 8'd0, 1'b1, 1, 1'b1,
      {4'd0, 16'd0, 8'd0, 20'd0, 20'd0, 24'd0, 24'd0, 5'd1, 1'b0, 1'b1}));
    // lone job, burst and priority at their high end
    job_table.push_back(job_row(16'hFFFF, 8'hFF, 1'b1, 1, 1'b1,
      {4'd0, 16'hFFFF, 8'hFF, 20'd0, 20'd65535, 24'd0, 24'd65535, 5'd1, 1'b0, 1'b1}));
    // tie on priority 5 keeps arrival order, priority 0 runs first
    job_table.push_back(job_row(16'd100, 8'd5, 1'b0, 1, 1'b0, '0));
    job_table.push_back(job_row(16'd200, 8'd3, 1'b0, 1, 1'b0, '0));
    job_table.push_back(job_row(16'd300, 8'd5, 1'b0, 1, 1'b0, '0));
    job_table.push_back(job_row(16'hFFFF, 8'd0, 1'b1, 1, 1'b0, '0));
    // arrival order fully reversed, with a zero burst in the middle
    job_table.push_back(job_row(16'd7, 8'd200, 1'b0, 1, 1'b0, '0));
    job_table.push_back(job_row(16'd0, 8'd100, 1'b0, 1, 1'b0, '0));
    job_table.push_back(job_row(16'd9, 8'd0, 1'b1, 1, 1'b0, '0));
    // batch full: sixteen max bursts, the closing job is discarded
    job_table.push_back(job_row(16'hFFFF, 8'hFF, 1'b0, 16, 1'b0, '0));
    job_table.push_back(job_row(16'd1, 8'd0, 1'b1, 1, 1'b0, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (job_table[r]) begin
      for (int k = 0; k < job_table[r].reps; k++)
        send_job(job_table[r].burst, job_table[r].prio, job_table[r].last,
                 job_table[r].typed, job_table[r].want);
    end

    sent = 0;
    batch = 0;
    while (sent < RANDOM_JOBS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      // long receiver hold-off while the sender keeps offering
      if (batch == 6) hold_req = 1'b1;
      // sender stops until every predicted result has arrived
      if (batch == 20 || batch == 45) begin
        in_valid_i <= 1'b0;
        while (schedule_q.size() != 0) @(posedge clk_i);
      end

      // mostly small batches, some full ones, a few that overflow
      pick = $urandom_range(0, 99);
      if (pick < 70) size = $urandom_range(1, 8);
      else if (pick < 85) size = $urandom_range(9, 15);
      else if (pick < 93) size = JOB_SLOTS;
      else size = $urandom_range(JOB_SLOTS + 1, JOB_SLOTS + 4);

      prio_style = $urandom_range(0, 2);
      burst_style = $urandom_range(0, 3);
      prio_fix = PRIO_W'($urandom_range(0, 255));
      for (int j = 0; j < size; j++) begin
        // few distinct priorities make many ties
        if (prio_style == 0) p = PRIO_W'($urandom_range(0, 255));
        else if (prio_style == 1) p = PRIO_W'($urandom_range(0, 3));
        else p = prio_fix;
        if (burst_style == 0) b = BURST_W'($urandom_range(0, 15));
        else if (burst_style == 1 && $urandom_range(0, 1)) b = 16'hFFFF;
        else b = BURST_W'($urandom_range(0, 65535));
        send_job(b, p, (j == size - 1), 1'b0, '0);
      end
      sent += size;
      batch++;
    end

    in_valid_i <= 1'b0;
    while (schedule_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (errors == 0 && schedule_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ nonpreemptive_priority_scheduler.f @@
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nonpreemptive_priority_scheduler.sv
test/nonpreemptive_priority_scheduler_tb.sv
